FILE: sv/pws_pkg.sv
// pws_pkg: shared types, constants and a helper function of the power window
// statistics block. No dependencies; every other file imports it.
package pws_pkg;

    localparam int SHORT_WINDOW = 3;
    localparam int MID_WINDOW   = 20 * 60;
    localparam int LONG_WINDOW  = 60 * 60;
    localparam int RING_DEPTH   = 4096;

    localparam int POWER_W    = 12;
    localparam int TIME_W     = 32;
    localparam int MEAN_W     = 16;
    localparam int TOTAL_W    = 44;
    localparam int COUNT_W    = 32;
    localparam int BSUM_W     = 32;
    localparam int BCNT_W     = 20;
    localparam int INTERVAL_W = 16;
    localparam int FRAC_W     = 4;

    localparam int POWER_MAX = (1 << POWER_W) - 1;
    localparam int PTR_W     = $clog2(RING_DEPTH);

    localparam int SHORT_SUM_W = $clog2((SHORT_WINDOW + 1) * POWER_MAX + 1);
    localparam int MID_SUM_W   = $clog2((MID_WINDOW + 1) * POWER_MAX + 1);
    localparam int LONG_SUM_W  = $clog2((LONG_WINDOW + 1) * POWER_MAX + 1);
    localparam int WSUM_W = (LONG_SUM_W > MID_SUM_W)
                          ? ((LONG_SUM_W > SHORT_SUM_W) ? LONG_SUM_W : SHORT_SUM_W)
                          : ((MID_SUM_W > SHORT_SUM_W) ? MID_SUM_W : SHORT_SUM_W);

    localparam int FILL_MAX = (LONG_WINDOW > MID_WINDOW)
                            ? ((LONG_WINDOW > SHORT_WINDOW) ? LONG_WINDOW : SHORT_WINDOW)
                            : ((MID_WINDOW > SHORT_WINDOW) ? MID_WINDOW : SHORT_WINDOW);
    localparam int FILL_W = $clog2(FILL_MAX + 1);

    // window means: floor(16 * sum / W) = (sum * RECIP) >> SHIFT, exact for every
    // sum of the register width since SHIFT spans the sum width plus the window width
    localparam int RECIP_W     = 32;
    localparam int PROD_W      = WSUM_W + RECIP_W;
    localparam int SHORT_SHIFT = SHORT_SUM_W + $clog2(SHORT_WINDOW);
    localparam int MID_SHIFT   = MID_SUM_W + $clog2(MID_WINDOW);
    localparam int LONG_SHIFT  = LONG_SUM_W + $clog2(LONG_WINDOW);
    localparam logic [RECIP_W-1:0] SHORT_RECIP = RECIP_W'(
        ((64'd1 << (SHORT_SHIFT + FRAC_W)) + 64'(SHORT_WINDOW) - 64'd1) / 64'(SHORT_WINDOW));
    localparam logic [RECIP_W-1:0] MID_RECIP = RECIP_W'(
        ((64'd1 << (MID_SHIFT + FRAC_W)) + 64'(MID_WINDOW) - 64'd1) / 64'(MID_WINDOW));
    localparam logic [RECIP_W-1:0] LONG_RECIP = RECIP_W'(
        ((64'd1 << (LONG_SHIFT + FRAC_W)) + 64'(LONG_WINDOW) - 64'd1) / 64'(LONG_WINDOW));

    // divider: dividend is a block sum in Q.4, divisor a block count
    localparam int DIVD_W = BSUM_W + FRAC_W;
    localparam int DIVS_W = BCNT_W;
    localparam int STEP_W = $clog2(MEAN_W);

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(30);

    typedef logic [1:0] win_idx_t;
    localparam win_idx_t WIN_SHORT = 2'd0;
    localparam win_idx_t WIN_MID   = 2'd1;
    localparam win_idx_t WIN_LONG  = 2'd2;
    localparam int WIN_NUM = 3;

    typedef struct packed {
        logic [POWER_W-1:0] power_watts;
        logic [TIME_W-1:0]  sample_time;
    } pws_in_t;

    typedef struct packed {
        logic [POWER_W-1:0] max_power;
        logic [MEAN_W-1:0]  short_avg;
        logic [MEAN_W-1:0]  short_best;
        logic [MEAN_W-1:0]  mid_avg;
        logic [MEAN_W-1:0]  mid_best;
        logic [MEAN_W-1:0]  long_avg;
        logic [MEAN_W-1:0]  long_best;
        logic [TOTAL_W-1:0] total_sum;
        logic [COUNT_W-1:0] sample_count;
        logic               block_done;
        logic [MEAN_W-1:0]  block_avg;
    } pws_out_t;

    // front-to-back record: sample plus everything the front already settled
    typedef struct packed {
        logic [POWER_W-1:0] power;
        logic [POWER_W-1:0] peak;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
        logic               done;
        logic [BSUM_W-1:0]  bsum;
        logic [BCNT_W-1:0]  bcnt;
    } pws_rec_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } pws_div_req_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_UPDATE,
        BK_MEAN,
        BK_BLOCK,
        BK_BLKWAIT,
        BK_COMMIT,
        BK_OUT
    } bk_state_t;

    function automatic logic [DIVS_W-1:0] window_len(win_idx_t k);
        logic [DIVS_W-1:0] len;
        unique case (k)
            WIN_SHORT: len = DIVS_W'(SHORT_WINDOW);
            WIN_MID:   len = DIVS_W'(MID_WINDOW);
            WIN_LONG:  len = DIVS_W'(LONG_WINDOW);
            default:   len = DIVS_W'(LONG_WINDOW);
        endcase
        return len;
    endfunction

endpackage

FILE: sv/pws_front.sv
// pws_front: accepts samples, keeps totals, peak and block accumulation,
// decides block close, queues records for the back end. Uses pws_pkg.
module pws_front import pws_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pws_in_t               item,
    input  logic                  push,
    output logic                  full,
    input  logic                  cfg_we,
    input  logic [INTERVAL_W-1:0] cfg_data,
    output pws_rec_t              rec,
    output logic                  rec_valid,
    input  logic                  rec_pop
);

    logic [INTERVAL_W-1:0] interval_reg;
    logic [POWER_W-1:0]    peak_reg, peak_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [BSUM_W-1:0]     bsum_reg, bsum_next;
    logic [BCNT_W-1:0]     bcnt_reg, bcnt_next;
    logic [TIME_W-1:0]     bstart_reg;
    logic [TOTAL_W:0]      total_wide;
    logic [TIME_W-1:0]     elapsed;
    logic                  close;
    logic                  accept;
    pws_rec_t              new_rec;

    pws_rec_t              slot_reg [2];
    logic                  head_reg;
    logic [1:0]            fill_reg, fill_next;
    logic                  tail;

    assign accept = push && !full;

    always_comb
    begin
        total_wide = {1'b0, total_reg} + (TOTAL_W + 1)'(item.power_watts);
        total_next = total_wide[TOTAL_W] ? '1 : total_wide[TOTAL_W-1:0];
        count_next = (count_reg == '1) ? count_reg : count_reg + COUNT_W'(1);
        peak_next  = (item.power_watts > peak_reg) ? item.power_watts : peak_reg;
        if (bcnt_reg != '1)
        begin
            bsum_next = bsum_reg + BSUM_W'(item.power_watts);
            bcnt_next = bcnt_reg + BCNT_W'(1);
        end
        else
        begin
            bsum_next = bsum_reg;
            bcnt_next = bcnt_reg;
        end
        elapsed = item.sample_time - bstart_reg;
        close   = elapsed > TIME_W'(interval_reg);

        new_rec.power = item.power_watts;
        new_rec.peak  = peak_next;
        new_rec.total = total_next;
        new_rec.count = count_next;
        new_rec.done  = close;
        new_rec.bsum  = bsum_next;
        new_rec.bcnt  = bcnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
            peak_reg     <= '0;
            total_reg    <= '0;
            count_reg    <= '0;
            bsum_reg     <= '0;
            bcnt_reg     <= '0;
            bstart_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                interval_reg <= cfg_data;
            end
            if (accept)
            begin
                peak_reg  <= peak_next;
                total_reg <= total_next;
                count_reg <= count_next;
                if (close)
                begin
                    bsum_reg   <= '0;
                    bcnt_reg   <= '0;
                    bstart_reg <= item.sample_time;
                end
                else
                begin
                    bsum_reg <= bsum_next;
                    bcnt_reg <= bcnt_next;
                end
            end
        end
    end

    // two-entry record queue
    assign full      = (fill_reg == 2'd2);
    assign rec_valid = (fill_reg != 2'd0);
    assign rec       = slot_reg[head_reg];
    assign tail      = head_reg ^ fill_reg[0];

    always_comb
    begin
        unique case ({accept, rec_pop && rec_valid})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (rec_pop && rec_valid)
            begin
                head_reg <= ~head_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[tail] <= new_rec;
        end
    end

endmodule

FILE: sv/pws_div.sv
// pws_div: restoring divider, one quotient bit per cycle, 16-bit quotient.
// Uses pws_pkg. Requires dividend < divisor * 2^MEAN_W.
module pws_div import pws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pws_div_req_t      req,
    output logic              done,
    output logic [MEAN_W-1:0] quotient
);

    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dsr_reg;
    logic [MEAN_W-1:0] low_reg;
    logic [MEAN_W-1:0] q_reg;
    logic [STEP_W-1:0] step_reg;
    logic              active_reg;
    logic              done_reg;
    logic [DIVS_W:0]   trial;
    logic              ge;

    always_comb
    begin
        trial    = {rem_reg, low_reg[MEAN_W-1]};
        ge       = trial >= {1'b0, dsr_reg};
        rem_next = ge ? DIVS_W'(trial - {1'b0, dsr_reg}) : DIVS_W'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                active_reg <= 1'b1;
                step_reg   <= '0;
            end
            else if (active_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MEAN_W - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= DIVS_W'(req.dividend[DIVD_W-1:MEAN_W]);
            low_reg <= req.dividend[MEAN_W-1:0];
            dsr_reg <= req.divisor;
        end
        else if (active_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[MEAN_W-2:0], 1'b0};
            q_reg   <= {q_reg[MEAN_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: sv/pws_back.sv
// pws_back: sample ring, window sums and means, block divider sequencing and
// the result register. Uses pws_pkg and pws_div.
module pws_back import pws_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pws_rec_t rec,
    input  logic     rec_valid,
    output logic     rec_pop,
    output pws_out_t result,
    output logic     empty,
    input  logic     pop
);

    bk_state_t state_reg, state_next;

    pws_rec_t               work_reg;
    win_idx_t               win_reg;
    logic [PTR_W-1:0]       wp_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [SHORT_SUM_W-1:0] short_sum_reg;
    logic [MID_SUM_W-1:0]   mid_sum_reg;
    logic [LONG_SUM_W-1:0]  long_sum_reg;
    logic [MEAN_W-1:0]      mean_reg [WIN_NUM];
    logic [MEAN_W-1:0]      best_reg [WIN_NUM];
    logic [MEAN_W-1:0]      bavg_reg;
    logic [POWER_W-1:0]     ring [RING_DEPTH];
    logic [POWER_W-1:0]     rd_data_reg;
    pws_out_t               out_reg;
    logic                   out_valid_reg;

    logic [DIVS_W-1:0]      wlen;
    logic [PTR_W:0]         addr_ext;
    logic [PTR_W-1:0]       rd_addr;
    logic                   filled;
    logic                   last_win;
    logic [WSUM_W-1:0]      sum_cur, sum_new;
    logic [RECIP_W-1:0]     recip;
    logic [PROD_W-1:0]      prod;
    logic [MEAN_W-1:0]      mean_q;
    logic                   ring_we;
    logic                   out_load;
    pws_div_req_t           div_req;
    logic                   div_done;
    logic [MEAN_W-1:0]      div_q;

    pws_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        wlen     = window_len(win_reg);
        last_win = (win_reg == WIN_LONG);
        filled   = DIVS_W'(fill_reg) >= wlen;
        if ((PTR_W + 1)'(wp_reg) >= (PTR_W + 1)'(wlen))
        begin
            addr_ext = (PTR_W + 1)'(wp_reg) - (PTR_W + 1)'(wlen);
        end
        else
        begin
            addr_ext = (PTR_W + 1)'(wp_reg) + (PTR_W + 1)'(RING_DEPTH) - (PTR_W + 1)'(wlen);
        end
        rd_addr = addr_ext[PTR_W-1:0];
        unique case (win_reg)
            WIN_SHORT: sum_cur = WSUM_W'(short_sum_reg);
            WIN_MID:   sum_cur = WSUM_W'(mid_sum_reg);
            default:   sum_cur = WSUM_W'(long_sum_reg);
        endcase
        sum_new = sum_cur + WSUM_W'(work_reg.power)
                - (filled ? WSUM_W'(rd_data_reg) : WSUM_W'(0));
        // mean from the already updated window sum register
        unique case (win_reg)
            WIN_SHORT: recip = SHORT_RECIP;
            WIN_MID:   recip = MID_RECIP;
            default:   recip = LONG_RECIP;
        endcase
        prod = PROD_W'(sum_cur) * PROD_W'(recip);
        unique case (win_reg)
            WIN_SHORT: mean_q = prod[SHORT_SHIFT +: MEAN_W];
            WIN_MID:   mean_q = prod[MID_SHIFT +: MEAN_W];
            default:   mean_q = prod[LONG_SHIFT +: MEAN_W];
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (rec_valid)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:   state_next = BK_UPDATE;
            BK_UPDATE:
            begin
                if (filled)
                begin
                    state_next = BK_MEAN;
                end
                else
                begin
                    state_next = last_win ? BK_BLOCK : BK_READ;
                end
            end
            BK_MEAN:   state_next = last_win ? BK_BLOCK : BK_READ;
            BK_BLOCK:  state_next = work_reg.done ? BK_BLKWAIT : BK_COMMIT;
            BK_BLKWAIT:
            begin
                if (div_done)
                begin
                    state_next = BK_COMMIT;
                end
            end
            BK_COMMIT: state_next = BK_OUT;
            BK_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:   state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        rec_pop          = (state_reg == BK_IDLE) && rec_valid;
        ring_we          = (state_reg == BK_COMMIT);
        out_load         = (state_reg == BK_OUT) && (!out_valid_reg || pop);
        div_req.start    = (state_reg == BK_BLOCK) && work_reg.done;
        div_req.dividend = {work_reg.bsum, {FRAC_W{1'b0}}};
        div_req.divisor  = work_reg.bcnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            win_reg       <= WIN_SHORT;
            wp_reg        <= '0;
            fill_reg      <= '0;
            short_sum_reg <= '0;
            mid_sum_reg   <= '0;
            long_sum_reg  <= '0;
            bavg_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WIN_NUM; i++)
            begin
                mean_reg[i] <= '0;
                best_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (rec_pop)
            begin
                win_reg <= WIN_SHORT;
            end
            if (state_reg == BK_UPDATE)
            begin
                unique case (win_reg)
                    WIN_SHORT: short_sum_reg <= SHORT_SUM_W'(sum_new);
                    WIN_MID:   mid_sum_reg   <= MID_SUM_W'(sum_new);
                    default:   long_sum_reg  <= LONG_SUM_W'(sum_new);
                endcase
                if (!filled)
                begin
                    win_reg <= win_reg + 2'd1;
                end
            end
            if (state_reg == BK_MEAN)
            begin
                mean_reg[win_reg] <= mean_q;
                if (mean_q > best_reg[win_reg])
                begin
                    best_reg[win_reg] <= mean_q;
                end
                win_reg <= win_reg + 2'd1;
            end
            if ((state_reg == BK_BLOCK) && !work_reg.done)
            begin
                bavg_reg <= '0;
            end
            if ((state_reg == BK_BLKWAIT) && div_done)
            begin
                bavg_reg <= div_q;
            end
            if (ring_we)
            begin
                wp_reg <= (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
                if (fill_reg < FILL_W'(FILL_MAX))
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            work_reg <= rec;
        end
        if (ring_we)
        begin
            ring[wp_reg] <= work_reg.power;
        end
        rd_data_reg <= ring[rd_addr];
        if (out_load)
        begin
            out_reg.max_power    <= work_reg.peak;
            out_reg.short_avg    <= mean_reg[WIN_SHORT];
            out_reg.short_best   <= best_reg[WIN_SHORT];
            out_reg.mid_avg      <= mean_reg[WIN_MID];
            out_reg.mid_best     <= best_reg[WIN_MID];
            out_reg.long_avg     <= mean_reg[WIN_LONG];
            out_reg.long_best    <= best_reg[WIN_LONG];
            out_reg.total_sum    <= work_reg.total;
            out_reg.sample_count <= work_reg.count;
            out_reg.block_done   <= work_reg.done;
            out_reg.block_avg    <= bavg_reg;
        end
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

endmodule

FILE: sv/power_window_statistics_core.sv
// power_window_statistics_core: top level of the power window statistics block.
// Depends on pws_pkg, pws_front, pws_back (which holds pws_div).
//
// Each power sample pushed in yields exactly one result transaction: peak power,
// saturating total and count, the short/mid/long sliding-window means with their
// best-ever holds (Q12.4, zero until the window has been full before the sample),
// and a block average when the sample time runs more than block_interval past the
// block start. In the back end an item goes through a ring read and a sum update
// per window, a reciprocal-multiply mean step for every filled window and, for a
// closing block, a wait on the one-bit-per-cycle divider. Up to two samples queue
// in the front while the back end works and one result waits on the result ports.
// The sample ring is not cleared; a window only reads it once filled.
// block_interval resets to 30 and is written through cfg_we/cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
module power_window_statistics_core import pws_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pws_in_t               item,
    input  logic                  push,
    output logic                  full,
    output pws_out_t              result,
    output logic                  empty,
    input  logic                  pop,
    input  logic                  cfg_we,
    input  logic [INTERVAL_W-1:0] cfg_data
);

    pws_rec_t rec;
    logic     rec_valid;
    logic     rec_pop;

    // front: bookkeeping and block close decision, record queue
    pws_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .full      (full),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .rec       (rec),
        .rec_valid (rec_valid),
        .rec_pop   (rec_pop)
    );

    // back: window sums over the ring, means, block division, result register
    pws_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (rec),
        .rec_valid (rec_valid),
        .rec_pop   (rec_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

`ifndef SYNTHESIS
    // back end never takes a record from an empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rec_pop |-> rec_valid)
        else $error("record popped from empty queue");

    // a full front queue always has a record for the back end
    a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> rec_valid)
        else $error("queue full but no record visible");

    // an accepted sample shows up in the queue the next cycle
    a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> rec_valid)
        else $error("accepted transaction missing from queue");

    // a waiting result is not dropped without a pop
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result lost without pop");
`endif

endmodule
